// File: sv/tp2rel_pkg.sv
// Shared codes for the touchpad to relative motion block: opcodes, result kinds, key codes.
package tp2rel_pkg;

	typedef enum logic [2:0] {
		OP_POS_X = 3'd0,
		OP_POS_Y = 3'd1,
		OP_KEY   = 3'd2,
		OP_SYNC  = 3'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_MOTION = 2'd0,
		KIND_WHEEL  = 2'd1,
		KIND_KEY    = 2'd2
	} kind_t;

	localparam logic [9:0] KEY_TOUCH         = 10'd330;
	localparam logic [9:0] KEY_ONE_FINGER    = 10'd325;
	localparam logic [9:0] KEY_TWO_FINGERS   = 10'd333;
	localparam logic [9:0] KEY_THREE_FINGERS = 10'd334;

	localparam logic [16:0] THRESHOLD_RESET = 17'd32;

endpackage

// File: sv/touchpad_to_relative_motion_core.sv
// Touchpad events to relative pointer motion, wheel steps and key passthrough.
//
//  channel   | signals                                        | direction
//  ----------+------------------------------------------------+----------
//  input     | in_valid, in_stall, opcode, key_code, value    | in
//  result    | out_valid, out_stall, kind, delta_x, delta_y,  | out
//            | out_key_code, out_key_value                    |
//  config    | cfg_wr_en, cfg_wr_data (filter threshold)      | in
//
// An event is taken into an input register, then decoded and applied to the finger and
// position state, with any result loaded into the output register.
// One event per cycle is sustained while no result is held.
// A held result stalls the input register, and the input stalls only while it is full.
// Reset clears the state, the flags and both valid bits and sets the threshold to 32.
module touchpad_to_relative_motion_core #(
	parameter int POSITION_BITS = 16,
	parameter int FRACTION_BITS = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [9:0]  key_code,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic signed [15:0] delta_x,
	output logic signed [15:0] delta_y,
	output logic [9:0]  out_key_code,
	output logic [15:0] out_key_value
);
	import tp2rel_pkg::*;

	localparam int SW = POSITION_BITS + FRACTION_BITS;
	localparam int DW = SW + 2;
	localparam int DIV_SH = FRACTION_BITS + 2;

	// Motion step: (a - b + D/2) / D, truncated toward zero, saturated to 16 bits.
	function automatic logic signed [15:0] motion_step(input logic [SW-1:0] a,
			input logic [SW-1:0] b);
		logic signed [DW-1:0] n;
		logic signed [DW-1:0] q;
		logic signed [31:0]   q32;
		logic signed [15:0]   r;
		n = DW'(a) - DW'(b) + DW'(1 << (DIV_SH - 1));
		if (n[DW-1]) begin
			n = n + DW'((1 << DIV_SH) - 1);
		end
		q = n >>> DIV_SH;
		q32 = 32'(q);
		if (q32 > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (q32 < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(q32);
		end
		return r;
	endfunction

	// Adaptive low-pass: (3*old + new + 2) / 4 when close, else the new sample.
	function automatic logic [SW-1:0] smooth(input logic [SW-1:0] old_v,
			input logic [SW-1:0] new_v, input logic [16:0] thr);
		logic [SW-1:0] diff;
		logic [SW+1:0] acc;
		diff = (old_v >= new_v) ? (old_v - new_v) : (new_v - old_v);
		acc = ((SW+2)'(old_v) << 1) + (SW+2)'(old_v) + (SW+2)'(new_v) + (SW+2)'(2);
		if (32'(diff) < 32'(thr)) begin
			return acc[SW+1:2];
		end
		return new_v;
	endfunction

	logic [16:0]   threshold_q;
	logic          vld_s1;
	logic [2:0]    op_s1;
	logic [9:0]    code_s1;
	logic [15:0]   val_s1;
	logic [SW-1:0] filt_x_q, prev_x_q, filt_y_q, prev_y_q;
	logic          x_seen_q, y_seen_q, one_q, two_q, three_q;

	logic [SW-1:0] filt_x_d, prev_x_d, filt_y_d, prev_y_d;
	logic          x_seen_d, y_seen_d, one_d, two_d, three_d;
	logic          emit;
	logic [1:0]    kind_d;
	logic signed [15:0] dx_d, dy_d;
	logic [9:0]    key_code_d;
	logic [15:0]   key_value_d;
	logic [SW-1:0] sample;
	logic signed [15:0] wheel_dx, mot_dx, mot_dy;
	logic          advance;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic signed [15:0] dx_q, dy_q;
	logic [9:0]    key_code_q;
	logic [15:0]   key_value_q;

	assign advance  = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !advance;

	assign sample = SW'(POSITION_BITS'(val_s1)) << FRACTION_BITS;
	assign wheel_dx = x_seen_q ? motion_step(prev_x_q, filt_x_q) : 16'sd0;
	assign mot_dx   = x_seen_q ? motion_step(filt_x_q, prev_x_q) : 16'sd0;
	assign mot_dy   = y_seen_q ? motion_step(filt_y_q, prev_y_q) : 16'sd0;

	always_comb begin
		filt_x_d = filt_x_q;
		prev_x_d = prev_x_q;
		filt_y_d = filt_y_q;
		prev_y_d = prev_y_q;
		x_seen_d = x_seen_q;
		y_seen_d = y_seen_q;
		one_d = one_q;
		two_d = two_q;
		three_d = three_q;
		emit = 1'b0;
		kind_d = KIND_MOTION;
		dx_d = 16'sd0;
		dy_d = 16'sd0;
		key_code_d = '0;
		key_value_d = '0;
		case (opcode_t'(op_s1))
			OP_POS_X: begin
				x_seen_d = 1'b1;
				if (!x_seen_q) begin
					prev_x_d = sample;
					filt_x_d = sample;
				end else begin
					prev_x_d = filt_x_q;
					filt_x_d = smooth(filt_x_q, sample, threshold_q);
				end
			end
			OP_POS_Y: begin
				y_seen_d = 1'b1;
				if (!y_seen_q) begin
					prev_y_d = sample;
					filt_y_d = sample;
				end else begin
					prev_y_d = filt_y_q;
					filt_y_d = smooth(filt_y_q, sample, threshold_q);
				end
			end
			OP_KEY: begin
				if (code_s1 == KEY_ONE_FINGER) begin
					x_seen_d = 1'b0;
					y_seen_d = 1'b0;
					one_d = (val_s1 != 16'd0);
				end else if (code_s1 == KEY_TWO_FINGERS) begin
					two_d = (val_s1 != 16'd0);
				end else if (code_s1 == KEY_THREE_FINGERS) begin
					three_d = (val_s1 != 16'd0);
				end else if (code_s1 != KEY_TOUCH) begin
					emit = 1'b1;
					kind_d = KIND_KEY;
					key_code_d = code_s1;
					key_value_d = val_s1;
				end
			end
			OP_SYNC: begin
				// Three fingers mute everything; two fingers win over one.
				if (three_q) begin
					emit = 1'b0;
				end else if (two_q) begin
					emit = (wheel_dx != 16'sd0);
					kind_d = KIND_WHEEL;
					dx_d = wheel_dx;
				end else if (one_q) begin
					emit = (mot_dx != 16'sd0) || (mot_dy != 16'sd0);
					kind_d = KIND_MOTION;
					dx_d = mot_dx;
					dy_d = mot_dy;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= opcode;
			code_s1 <= key_code;
			val_s1 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_x_q <= '0;
			prev_x_q <= '0;
			filt_y_q <= '0;
			prev_y_q <= '0;
			x_seen_q <= 1'b0;
			y_seen_q <= 1'b0;
			one_q <= 1'b0;
			two_q <= 1'b0;
			three_q <= 1'b0;
		end else if (advance) begin
			filt_x_q <= filt_x_d;
			prev_x_q <= prev_x_d;
			filt_y_q <= filt_y_d;
			prev_y_q <= prev_y_d;
			x_seen_q <= x_seen_d;
			y_seen_q <= y_seen_d;
			one_q <= one_d;
			two_q <= two_d;
			three_q <= three_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= kind_d;
			dx_q <= dx_d;
			dy_q <= dy_d;
			key_code_q <= key_code_d;
			key_value_q <= key_value_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign delta_x       = dx_q;
	assign delta_y       = dy_q;
	assign out_key_code  = key_code_q;
	assign out_key_value = key_value_q;

endmodule

// File: sv/tp2rel_checker.sv
// Port-level checks for the touchpad to relative motion block, bound to its top level.
module tp2rel_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic signed [15:0] delta_x,
	input logic signed [15:0] delta_y,
	input logic [9:0]  out_key_code,
	input logic [15:0] out_key_value
);
	import tp2rel_pkg::*;

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_MOTION || kind == KIND_WHEEL || kind == KIND_KEY))
		else $error("result beat with an unused kind code");

	// Motion and wheel beats never carry an all-zero movement.
	a_no_zero_motion: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_KEY |-> (delta_x != 16'sd0 || delta_y != 16'sd0))
		else $error("motion beat with zero deltas");

	a_wheel_no_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_WHEEL |-> delta_y == 16'sd0)
		else $error("wheel beat with vertical delta");

	a_key_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_KEY |-> (out_key_code == 10'd0 && out_key_value == 16'd0))
		else $error("motion beat with key fields set");

endmodule

bind touchpad_to_relative_motion_core tp2rel_checker u_tp2rel_checker (.*);
